>>> rtl/core/obb_pkg.sv
package obb_pkg;

    localparam int FRAC_BITS        = 16;
    localparam int TRIG_W           = 18;
    localparam int CORDIC_W         = 34;
    localparam int ATAN_ENTRIES     = 24;
    localparam int CORDIC_K_Q30     = 652032874;
    localparam int TOL_W            = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd655;

    localparam int COORD_W_DEF      = 32;
    localparam int ANGLE_W_DEF      = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    typedef logic signed [TRIG_W-1:0] trig_t;

    // atan(2^-i) as a fraction of a 32-bit turn
    function automatic logic signed [CORDIC_W-1:0] atan_turn(input int i);
        logic signed [CORDIC_W-1:0] v;
        case (i)
            0:       v = 34'sd536870912;
            1:       v = 34'sd316933406;
            2:       v = 34'sd167458907;
            3:       v = 34'sd85004756;
            4:       v = 34'sd42667331;
            5:       v = 34'sd21354465;
            6:       v = 34'sd10679838;
            7:       v = 34'sd5340245;
            8:       v = 34'sd2670163;
            9:       v = 34'sd1335087;
            10:      v = 34'sd667544;
            11:      v = 34'sd333772;
            12:      v = 34'sd166886;
            13:      v = 34'sd83443;
            14:      v = 34'sd41722;
            15:      v = 34'sd20861;
            16:      v = 34'sd10430;
            17:      v = 34'sd5215;
            18:      v = 34'sd2608;
            19:      v = 34'sd1304;
            20:      v = 34'sd652;
            21:      v = 34'sd326;
            22:      v = 34'sd163;
            23:      v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/obb_pair_sat_contact_top.sv
// Channel  | Dir | Handshake                 | Word
// s_axis   | in  | s_axis_tvalid/tready      | box pair (tdata)
// m_axis   | out | m_axis_tvalid/tready      | hit, normal, depth, contacts (tdata)
// cfg      | in  | cfg_we                    | contact_tolerance (cfg_wdata)
//
// One word in per cycle, CORDIC_STEPS + 13 register stages deep (29 at defaults).
// The depth is set by the CORDIC rotation steps, one step per stage.
// rst_n clears the valid bits and resets the tolerance to 655.
// All stages advance together; a stall at m_axis holds the whole pipe,
// and s_axis_tready is high only while the output word is empty or being taken.
module obb_pair_sat_contact_top
    import obb_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_W_DEF,
    parameter int ANGLE_WIDTH  = ANGLE_W_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [TOL_W-1:0] cfg_wdata,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // center_ax, center_ay, half_ax, half_ay, angle_a,
    // center_bx, center_by, half_bx, half_by, angle_b
    input  logic [((4*COORD_WIDTH+4*(COORD_WIDTH-1)+2*ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // hit, normal_x, normal_y, penetration, contact_count,
    // contact0_x, contact0_y, contact1_x, contact1_y
    output logic [((5*COORD_WIDTH+38+7)/8)*8-1:0] m_axis_tdata
);

    localparam int CW  = COORD_WIDTH;
    localparam int HW  = CW - 1;
    localparam int AW  = ANGLE_WIDTH;
    localparam int PRW = CW + TRIG_W;
    localparam int KW  = CW + 4;
    localparam int QW  = KW + TRIG_W;
    localparam int PW  = KW + 3;
    localparam int OW  = PW + 1;
    localparam int OUT_RAW = 5*CW + 38;
    localparam int D   = CORDIC_STEPS + 2;
    localparam int NS  = D + 11;

    localparam int O_CAX = 0;
    localparam int O_CAY = O_CAX + CW;
    localparam int O_HAX = O_CAY + CW;
    localparam int O_HAY = O_HAX + HW;
    localparam int O_ANA = O_HAY + HW;
    localparam int O_CBX = O_ANA + AW;
    localparam int O_CBY = O_CBX + CW;
    localparam int O_HBX = O_CBY + CW;
    localparam int O_HBY = O_HBX + HW;
    localparam int O_ANB = O_HBY + HW;
    localparam int BOX_W = 2*CW + 2*HW;

    localparam logic signed [OW-1:0] PEN_MAX = OW'((64'd1 << HW) - 64'd1);
    localparam logic signed [KW-1:0] CMAX    = KW'((64'd1 << (CW-1)) - 64'd1);
    localparam logic signed [KW-1:0] CMIN    = -CMAX - KW'(1);

    logic            en;
    logic [NS-1:0]   vld_reg;
    logic [TOL_W-1:0] tol_reg;

    // stage 0: input word
    logic [AW-1:0]    ang_a_reg, ang_b_reg;
    logic [2*BOX_W-1:0] box_reg;
    logic [2*BOX_W-1:0] dly_reg [D];
    trig_t ca, sa, cb, sb;

    // P1: half extent products, box b, {hx*c, hx*s, hy*s, hy*c}
    logic signed [PRW-1:0] hp_reg [8];
    logic signed [CW-1:0]  c1_reg [4];
    trig_t                 t1_reg [4];

    // P2: world corners, A in 0..3, B in 4..7
    logic signed [KW-1:0]  k2x_reg [8], k2y_reg [8];
    logic signed [CW:0]    dx2_reg, dy2_reg;
    trig_t                 t2_reg [4];

    // P3: projection products
    logic signed [QW-1:0]  px3_reg [4][8], py3_reg [4][8];
    logic signed [QW-1:0]  cx3_reg [4], cy3_reg [4];
    logic signed [KW-1:0]  k3x_reg [8], k3y_reg [8];
    trig_t                 t3_reg [4];
    trig_t                 axx3 [4], axy3 [4];

    // P4: projections
    logic signed [PW-1:0]  pr4_reg [4][8];
    logic [3:0]            neg4_reg;
    logic signed [KW-1:0]  k4x_reg [8], k4y_reg [8];
    trig_t                 t4_reg [4];

    // P5: extents per axis
    logic signed [PW-1:0]  mna5_reg [4], mxa5_reg [4], mnb5_reg [4], mxb5_reg [4];
    logic [3:0]            neg5_reg;
    logic signed [KW-1:0]  k5x_reg [8], k5y_reg [8];
    trig_t                 t5_reg [4];

    // P6: overlaps
    logic signed [OW-1:0]  ov6_reg [4];
    logic                  sep6_reg;
    logic [3:0]            neg6_reg;
    logic signed [KW-1:0]  k6x_reg [8], k6y_reg [8];
    trig_t                 t6_reg [4];

    // P7: chosen axis and support corners
    logic signed [OW-1:0]  best7_reg;
    logic                  sep7_reg, froma7_reg;
    trig_t                 nx7_reg, ny7_reg;
    logic signed [KW-1:0]  s7x_reg [4], s7y_reg [4];

    // P8, P9: contact depths
    logic signed [QW-1:0]  dpx8_reg [4], dpy8_reg [4];
    logic signed [OW-1:0]  best8_reg, best9_reg;
    logic                  sep8_reg, froma8_reg, sep9_reg, froma9_reg;
    trig_t                 nx8_reg, ny8_reg, nx9_reg, ny9_reg;
    logic signed [KW-1:0]  s8x_reg [4], s8y_reg [4], s9x_reg [4], s9y_reg [4];
    logic signed [PW-1:0]  dp9_reg [4];

    // output word
    logic                  hit_reg;
    trig_t                 onx_reg, ony_reg;
    logic [HW-1:0]         pen_reg;
    logic [1:0]            cnt_reg;
    logic [CW-1:0]         c0x_reg, c0y_reg, c1x_reg, c1y_reg;

    function automatic logic signed [KW-1:0] q16(input logic signed [PRW-1:0] p);
        return KW'($signed(p[PRW-1:FRAC_BITS]));
    endfunction

    function automatic logic signed [PW-1:0] dot16(input logic signed [QW-1:0] a,
                                                   input logic signed [QW-1:0] b);
        return PW'($signed(a[QW-1:FRAC_BITS])) + PW'($signed(b[QW-1:FRAC_BITS]));
    endfunction

    function automatic logic [CW-1:0] sat_coord(input logic signed [KW-1:0] v);
        logic [CW-1:0] o;
        if (v > CMAX)
        begin
            o = CMAX[CW-1:0];
        end
        else if (v < CMIN)
        begin
            o = CMIN[CW-1:0];
        end
        else
        begin
            o = v[CW-1:0];
        end
        return o;
    endfunction

    assign en            = !vld_reg[NS-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            tol_reg <= TOL_RESET;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[NS-2:0], s_axis_tvalid};
            end
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
        end
    end

    // stage 0 and the delay that keeps the boxes beside the CORDIC
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_a_reg  <= s_axis_tdata[O_ANA +: AW];
            ang_b_reg  <= s_axis_tdata[O_ANB +: AW];
            box_reg    <= {s_axis_tdata[O_CBX +: BOX_W], s_axis_tdata[O_CAX +: BOX_W]};
            dly_reg[0] <= box_reg;
            for (int j = 1; j < D; j++)
            begin
                dly_reg[j] <= dly_reg[j-1];
            end
        end
    end

    obb_cordic #(
        .ANGLE_WIDTH  (ANGLE_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic_a (
        .clk   (clk),
        .en    (en),
        .angle (ang_a_reg),
        .cos_q (ca),
        .sin_q (sa)
    );

    obb_cordic #(
        .ANGLE_WIDTH  (ANGLE_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic_b (
        .clk   (clk),
        .en    (en),
        .angle (ang_b_reg),
        .cos_q (cb),
        .sin_q (sb)
    );

    // P1
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int b = 0; b < 2; b++)
            begin
                logic signed [CW-1:0] hx, hy;
                trig_t c, s;
                hx = $signed({1'b0, dly_reg[D-1][b*BOX_W + 2*CW +: HW]});
                hy = $signed({1'b0, dly_reg[D-1][b*BOX_W + 2*CW + HW +: HW]});
                c  = (b == 0) ? ca : cb;
                s  = (b == 0) ? sa : sb;
                hp_reg[4*b]   <= PRW'(hx * c);
                hp_reg[4*b+1] <= PRW'(hx * s);
                hp_reg[4*b+2] <= PRW'(hy * s);
                hp_reg[4*b+3] <= PRW'(hy * c);
                c1_reg[2*b]   <= $signed(dly_reg[D-1][b*BOX_W +: CW]);
                c1_reg[2*b+1] <= $signed(dly_reg[D-1][b*BOX_W + CW +: CW]);
            end
            t1_reg <= '{ca, sa, cb, sb};
        end
    end

    // P2: a negative extent needs the product negated before the floor
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int b = 0; b < 2; b++)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    logic sxp, syp;
                    logic signed [KW-1:0] mxc, mxs, mys, myc;
                    sxp = (i == 1) || (i == 2);
                    syp = (i >= 2);
                    mxc = sxp ? q16(hp_reg[4*b])   : q16(-hp_reg[4*b]);
                    mxs = sxp ? q16(hp_reg[4*b+1]) : q16(-hp_reg[4*b+1]);
                    mys = syp ? q16(hp_reg[4*b+2]) : q16(-hp_reg[4*b+2]);
                    myc = syp ? q16(hp_reg[4*b+3]) : q16(-hp_reg[4*b+3]);
                    k2x_reg[4*b+i] <= KW'(c1_reg[2*b]) + mxc - mys;
                    k2y_reg[4*b+i] <= KW'(c1_reg[2*b+1]) + mxs + myc;
                end
            end
            dx2_reg <= (CW+1)'(c1_reg[2]) - (CW+1)'(c1_reg[0]);
            dy2_reg <= (CW+1)'(c1_reg[3]) - (CW+1)'(c1_reg[1]);
            t2_reg  <= t1_reg;
        end
    end

    // P3: axes A-right, A-up, B-right, B-up
    always_comb
    begin
        axx3[0] = t2_reg[0];
        axy3[0] = t2_reg[1];
        axx3[1] = -t2_reg[1];
        axy3[1] = t2_reg[0];
        axx3[2] = t2_reg[2];
        axy3[2] = t2_reg[3];
        axx3[3] = -t2_reg[3];
        axy3[3] = t2_reg[2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 4; a++)
            begin
                for (int k = 0; k < 8; k++)
                begin
                    px3_reg[a][k] <= QW'(k2x_reg[k] * axx3[a]);
                    py3_reg[a][k] <= QW'(k2y_reg[k] * axy3[a]);
                end
                cx3_reg[a] <= QW'(dx2_reg * axx3[a]);
                cy3_reg[a] <= QW'(dy2_reg * axy3[a]);
            end
            k3x_reg <= k2x_reg;
            k3y_reg <= k2y_reg;
            t3_reg  <= t2_reg;
        end
    end

    // P4
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 4; a++)
            begin
                logic signed [PW-1:0] cd;
                for (int k = 0; k < 8; k++)
                begin
                    pr4_reg[a][k] <= dot16(px3_reg[a][k], py3_reg[a][k]);
                end
                cd = dot16(cx3_reg[a], cy3_reg[a]);
                neg4_reg[a] <= cd[PW-1];
            end
            k4x_reg <= k3x_reg;
            k4y_reg <= k3y_reg;
            t4_reg  <= t3_reg;
        end
    end

    // P5: min/max trees over four corners per box
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 4; a++)
            begin
                logic signed [PW-1:0] l0, l1, h0, h1, l2, l3, h2, h3;
                l0 = (pr4_reg[a][1] < pr4_reg[a][0]) ? pr4_reg[a][1] : pr4_reg[a][0];
                l1 = (pr4_reg[a][3] < pr4_reg[a][2]) ? pr4_reg[a][3] : pr4_reg[a][2];
                h0 = (pr4_reg[a][1] > pr4_reg[a][0]) ? pr4_reg[a][1] : pr4_reg[a][0];
                h1 = (pr4_reg[a][3] > pr4_reg[a][2]) ? pr4_reg[a][3] : pr4_reg[a][2];
                l2 = (pr4_reg[a][5] < pr4_reg[a][4]) ? pr4_reg[a][5] : pr4_reg[a][4];
                l3 = (pr4_reg[a][7] < pr4_reg[a][6]) ? pr4_reg[a][7] : pr4_reg[a][6];
                h2 = (pr4_reg[a][5] > pr4_reg[a][4]) ? pr4_reg[a][5] : pr4_reg[a][4];
                h3 = (pr4_reg[a][7] > pr4_reg[a][6]) ? pr4_reg[a][7] : pr4_reg[a][6];
                mna5_reg[a] <= (l1 < l0) ? l1 : l0;
                mxa5_reg[a] <= (h1 > h0) ? h1 : h0;
                mnb5_reg[a] <= (l3 < l2) ? l3 : l2;
                mxb5_reg[a] <= (h3 > h2) ? h3 : h2;
            end
            neg5_reg <= neg4_reg;
            k5x_reg  <= k4x_reg;
            k5y_reg  <= k4y_reg;
            t5_reg   <= t4_reg;
        end
    end

    // P6
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic gap;
            gap = 1'b0;
            for (int a = 0; a < 4; a++)
            begin
                logic signed [PW-1:0] hi, lo;
                hi = (mxa5_reg[a] < mxb5_reg[a]) ? mxa5_reg[a] : mxb5_reg[a];
                lo = (mna5_reg[a] > mnb5_reg[a]) ? mna5_reg[a] : mnb5_reg[a];
                ov6_reg[a] <= OW'(hi) - OW'(lo);
                if ((mxa5_reg[a] < mnb5_reg[a]) || (mxb5_reg[a] < mna5_reg[a]))
                begin
                    gap = 1'b1;
                end
            end
            sep6_reg <= gap;
            neg6_reg <= neg5_reg;
            k6x_reg  <= k5x_reg;
            k6y_reg  <= k5y_reg;
            t6_reg   <= t5_reg;
        end
    end

    // P7: first strictly smallest overlap wins
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic signed [OW-1:0] bv;
            logic [1:0] idx;
            trig_t ax, ay;
            bv  = ov6_reg[0];
            idx = 2'd0;
            for (int a = 1; a < 4; a++)
            begin
                if (ov6_reg[a] < bv)
                begin
                    bv  = ov6_reg[a];
                    idx = 2'(a);
                end
            end
            case (idx)
                2'd0:
                begin
                    ax = t6_reg[0];
                    ay = t6_reg[1];
                end
                2'd1:
                begin
                    ax = -t6_reg[1];
                    ay = t6_reg[0];
                end
                2'd2:
                begin
                    ax = t6_reg[2];
                    ay = t6_reg[3];
                end
                default:
                begin
                    ax = -t6_reg[3];
                    ay = t6_reg[2];
                end
            endcase
            best7_reg  <= bv;
            froma7_reg <= !idx[1];
            sep7_reg   <= sep6_reg;
            nx7_reg    <= neg6_reg[idx] ? -ax : ax;
            ny7_reg    <= neg6_reg[idx] ? -ay : ay;
            for (int i = 0; i < 4; i++)
            begin
                s7x_reg[i] <= idx[1] ? k6x_reg[i] : k6x_reg[i+4];
                s7y_reg[i] <= idx[1] ? k6y_reg[i] : k6y_reg[i+4];
            end
        end
    end

    // P8, P9
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                dpx8_reg[i] <= QW'(s7x_reg[i] * nx7_reg);
                dpy8_reg[i] <= QW'(s7y_reg[i] * ny7_reg);
                dp9_reg[i]  <= dot16(dpx8_reg[i], dpy8_reg[i]);
            end
            best8_reg  <= best7_reg;
            froma8_reg <= froma7_reg;
            sep8_reg   <= sep7_reg;
            nx8_reg    <= nx7_reg;
            ny8_reg    <= ny7_reg;
            s8x_reg    <= s7x_reg;
            s8y_reg    <= s7y_reg;
            best9_reg  <= best8_reg;
            froma9_reg <= froma8_reg;
            sep9_reg   <= sep8_reg;
            nx9_reg    <= nx8_reg;
            ny9_reg    <= ny8_reg;
            s9x_reg    <= s8x_reg;
            s9y_reg    <= s8y_reg;
        end
    end

    // output: deepest corners, ties within the tolerance
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic [1:0] cnt;
            logic signed [OW-1:0] rv, pe, tl, df;
            logic signed [KW-1:0] k0x, k0y, k1x, k1y;
            logic restart;
            cnt = 2'd0;
            rv  = '0;
            k0x = '0;
            k0y = '0;
            k1x = '0;
            k1y = '0;
            tl  = $signed({{(OW-TOL_W){1'b0}}, tol_reg});
            for (int i = 0; i < 4; i++)
            begin
                pe = OW'(dp9_reg[i]);
                df = (pe >= rv) ? pe - rv : rv - pe;
                restart = froma9_reg ? (pe < rv - tl) : (pe > rv + tl);
                if (cnt == 2'd0 || restart)
                begin
                    rv  = pe;
                    cnt = 2'd1;
                    k0x = s9x_reg[i];
                    k0y = s9y_reg[i];
                end
                else if (df <= tl)
                begin
                    if (cnt == 2'd1)
                    begin
                        k1x = s9x_reg[i];
                        k1y = s9y_reg[i];
                        cnt = 2'd2;
                    end
                end
            end
            if (sep9_reg)
            begin
                hit_reg <= 1'b0;
                onx_reg <= '0;
                ony_reg <= '0;
                pen_reg <= '0;
                cnt_reg <= '0;
                c0x_reg <= '0;
                c0y_reg <= '0;
                c1x_reg <= '0;
                c1y_reg <= '0;
            end
            else
            begin
                hit_reg <= 1'b1;
                onx_reg <= nx9_reg;
                ony_reg <= ny9_reg;
                pen_reg <= (best9_reg > PEN_MAX) ? PEN_MAX[HW-1:0] : best9_reg[HW-1:0];
                cnt_reg <= cnt;
                c0x_reg <= sat_coord(k0x);
                c0y_reg <= sat_coord(k0y);
                c1x_reg <= (cnt == 2'd2) ? sat_coord(k1x) : '0;
                c1y_reg <= (cnt == 2'd2) ? sat_coord(k1y) : '0;
            end
        end
    end

    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[OUT_RAW-1:0] = {c1y_reg, c1x_reg, c0y_reg, c0x_reg, cnt_reg,
                                     pen_reg, ony_reg, onx_reg, hit_reg};
    end

    a_miss_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !hit_reg |-> cnt_reg == 2'd0 && pen_reg == '0)
        else $error("miss word carries contacts or depth");

    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && hit_reg |-> cnt_reg == 2'd1 || cnt_reg == 2'd2)
        else $error("hit word with bad contact count");

    a_single_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && cnt_reg != 2'd2 |-> c1x_reg == '0 && c1y_reg == '0)
        else $error("second contact set without a second support");

endmodule

>>> rtl/core/obb_cordic.sv
module obb_cordic
    import obb_pkg::*;
#(
    parameter int ANGLE_WIDTH  = ANGLE_W_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                   clk,
    input  logic                   en,
    input  logic [ANGLE_WIDTH-1:0] angle,
    output trig_t                  cos_q,
    output trig_t                  sin_q
);

    localparam logic signed [CORDIC_W-1:0] X_INIT = CORDIC_W'(CORDIC_K_Q30);

    logic signed [CORDIC_W-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] z_reg [CORDIC_STEPS+1];
    logic [1:0]                 q_reg [CORDIC_STEPS+1];
    trig_t                      cos_reg;
    trig_t                      sin_reg;

    logic [31:0]                th;
    logic [31:0]                th_bias;
    logic [1:0]                 q_next;
    logic [31:0]                rt;
    trig_t                      xr;
    trig_t                      yr;

    function automatic trig_t round_clamp(input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W:0]    s;
        logic signed [CORDIC_W-14:0] r;
        trig_t                       o;
        s = {v[CORDIC_W-1], v} + (CORDIC_W+1)'(8192);
        r = $signed(s[CORDIC_W:14]);
        if (r > (CORDIC_W-13)'(65536)) begin
            o = TRIG_W'(65536);
        end
        else if (r < -(CORDIC_W-13)'(65536)) begin
            o = -TRIG_W'(65536);
        end
        else begin
            o = $signed(r[TRIG_W-1:0]);
        end
        return o;
    endfunction

    // split off the nearest quarter turn, rotate the residual
    assign th      = 32'(angle) << (32 - ANGLE_WIDTH);
    assign th_bias = th + 32'h2000_0000;
    assign q_next  = th_bias[31:30];
    assign rt      = th - {q_next, 30'b0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= X_INIT;
            y_reg[0] <= '0;
            z_reg[0] <= $signed({{(CORDIC_W-32){rt[31]}}, rt});
            q_reg[0] <= q_next;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[k][CORDIC_W-1])
                begin
                    x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] - atan_turn(k);
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] + atan_turn(k);
                end
                q_reg[k+1] <= q_reg[k];
            end
        end
    end

    assign xr = round_clamp(x_reg[CORDIC_STEPS]);
    assign yr = round_clamp(y_reg[CORDIC_STEPS]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            case (q_reg[CORDIC_STEPS])
                2'd0:
                begin
                    cos_reg <= xr;
                    sin_reg <= yr;
                end
                2'd1:
                begin
                    cos_reg <= -yr;
                    sin_reg <= xr;
                end
                2'd2:
                begin
                    cos_reg <= -xr;
                    sin_reg <= -yr;
                end
                default:
                begin
                    cos_reg <= yr;
                    sin_reg <= -xr;
                end
            endcase
        end
    end

    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule

>>> tb/obb_pair_sat_contact_top_tb.sv
`timescale 1ns / 100ps

module obb_pair_sat_contact_top_tb
    import obb_pkg::*;
();

    localparam int IN_W  = 288;
    localparam int OUT_W = 200;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic signed [31:0] ax, ay;
        logic [30:0]        hax, hay;
        logic [15:0]        anga;
        logic signed [31:0] bx, by;
        logic [30:0]        hbx, hby;
        logic [15:0]        angb;
        bit                 apart;  // boxes are clearly separated: all result fields zero
    } pair_row_t;

    localparam longint ATAN_TURN [16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };
    localparam int FLD_LO [9] = '{0, 1, 19, 37, 68, 70, 102, 134, 166};
    localparam int FLD_W  [9] = '{1, 18, 18, 31, 2, 32, 32, 32, 32};
    localparam string FLD_NAME [9] = '{"hit", "normal_x", "normal_y", "penetration",
        "contact_count", "contact0_x", "contact0_y", "contact1_x", "contact1_y"};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [TOL_W-1:0] cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    logic [OUT_W-1:0] pending_words[$];
    longint tol_now = 655;
    int tx_idle = 0;
    int rx_idle = 0;
    int hold_left = 0;
    int errors = 0;
    int words_in = 0;
    int words_out = 0;
    int hits_seen = 0;

    obb_pair_sat_contact_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint qmul(input longint a, input longint b);
        longint ah, al;
        ah = a >>> 16;
        al = a - ah * 65536;
        return ah * b + ((al * b) >>> 16);
    endfunction

    function automatic longint qdot(input longint x, input longint y,
                                    input longint ux, input longint uy);
        return qmul(x, ux) + qmul(y, uy);
    endfunction

    function automatic void sincos(input logic [15:0] ang, output longint c,
                                   output longint s);
        logic [31:0] th, rt;
        logic [1:0]  q;
        longint z, x, y, nx;
        th = {ang, 16'h0};
        q = 2'((th + 32'h2000_0000) >> 30);
        rt = th - {q, 30'b0};
        z = longint'(signed'(rt));
        x = CORDIC_K_Q30;
        y = 0;
        for (int i = 0; i < 16; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= ATAN_TURN[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += ATAN_TURN[i];
            end
            x = nx;
        end
        x = (x + 8192) >>> 14;
        y = (y + 8192) >>> 14;
        if (x > 65536) x = 65536;
        if (x < -65536) x = -65536;
        if (y > 65536) y = 65536;
        if (y < -65536) y = -65536;
        case (q)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic void box_corners(input longint px, input longint py,
        input longint hx, input longint hy, input longint c, input longint s,
        output longint kx[4], output longint ky[4]);
        longint lx, ly;
        for (int i = 0; i < 4; i++)
        begin
            lx = (i == 0 || i == 3) ? -hx : hx;
            ly = (i < 2) ? -hy : hy;
            kx[i] = px + qmul(lx, c) - qmul(ly, s);
            ky[i] = py + qmul(lx, s) + qmul(ly, c);
        end
    endfunction

    function automatic logic [31:0] sat32(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Contact normal, depth and deepest corners for one box pair.
    function automatic logic [OUT_W-1:0] sat_contact(input pair_row_t r);
        longint ca, sa, cb, sb, dx, dy, best, nx, ny, pr, mna, mxa, mnb, mxb, ov;
        longint acx[4], acy[4], bcx[4], bcy[4], ux[4], uy[4], px[4], py[4];
        longint kx[2], ky[2];
        bit from_a, deeper;
        int cnt;
        logic [OUT_W-1:0] w;
        sincos(r.anga, ca, sa);
        sincos(r.angb, cb, sb);
        box_corners(r.ax, r.ay, r.hax, r.hay, ca, sa, acx, acy);
        box_corners(r.bx, r.by, r.hbx, r.hby, cb, sb, bcx, bcy);
        ux = '{ca, -sa, cb, -sb};
        uy = '{sa, ca, sb, cb};
        dx = longint'(r.bx) - longint'(r.ax);
        dy = longint'(r.by) - longint'(r.ay);
        best = 0; nx = 0; ny = 0; from_a = 0;
        for (int i = 0; i < 4; i++)
        begin
            mna = qdot(acx[0], acy[0], ux[i], uy[i]); mxa = mna;
            mnb = qdot(bcx[0], bcy[0], ux[i], uy[i]); mxb = mnb;
            for (int j = 1; j < 4; j++)
            begin
                pr = qdot(acx[j], acy[j], ux[i], uy[i]);
                if (pr < mna) mna = pr;
                if (pr > mxa) mxa = pr;
                pr = qdot(bcx[j], bcy[j], ux[i], uy[i]);
                if (pr < mnb) mnb = pr;
                if (pr > mxb) mxb = pr;
            end
            if (mxa < mnb || mxb < mna)
                return '0;
            ov = ((mxa < mxb) ? mxa : mxb) - ((mna > mnb) ? mna : mnb);
            if (i == 0 || ov < best)
            begin
                best = ov;
                from_a = (i < 2);
                nx = ux[i];
                ny = uy[i];
                if (qdot(dx, dy, nx, ny) < 0)
                begin
                    nx = -nx;
                    ny = -ny;
                end
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            px[i] = from_a ? bcx[i] : acx[i];
            py[i] = from_a ? bcy[i] : acy[i];
        end
        cnt = 0; ov = 0; kx = '{0, 0}; ky = '{0, 0};
        for (int i = 0; i < 4; i++)
        begin
            pr = qdot(px[i], py[i], nx, ny);
            deeper = from_a ? (pr < ov - tol_now) : (pr > ov + tol_now);
            if (cnt == 0 || deeper)
            begin
                ov = pr;
                cnt = 1;
                kx[0] = px[i];
                ky[0] = py[i];
            end
            else if (((pr >= ov) ? pr - ov : ov - pr) <= tol_now)
            begin
                if (cnt == 1)
                begin
                    kx[1] = px[i];
                    ky[1] = py[i];
                    cnt = 2;
                end
            end
        end
        if (best > 64'sd2147483647) best = 64'sd2147483647;
        w = '0;
        w[0] = 1'b1;
        w[18:1] = nx[17:0];
        w[36:19] = ny[17:0];
        w[67:37] = best[30:0];
        w[69:68] = cnt[1:0];
        w[101:70] = sat32(kx[0]);
        w[133:102] = sat32(ky[0]);
        if (cnt == 2)
        begin
            w[165:134] = sat32(kx[1]);
            w[197:166] = sat32(ky[1]);
        end
        return w;
    endfunction

    function automatic logic [IN_W-1:0] pack_pair(input pair_row_t r);
        return {4'b0, r.angb, r.hby, r.hbx, r.by, r.bx, r.anga, r.hay, r.hax, r.ay, r.ax};
    endfunction

    function automatic pair_row_t rand_pair();
        pair_row_t r;
        int mode;
        mode = $urandom_range(9);
        r.apart = 0;
        r.ax = $urandom; r.ay = $urandom; r.bx = $urandom; r.by = $urandom;
        r.hax = 31'($urandom); r.hay = 31'($urandom);
        r.hbx = 31'($urandom); r.hby = 31'($urandom);
        r.anga = 16'($urandom); r.angb = 16'($urandom);
        if (mode == 2)
        begin
            r.hax = $urandom_range(1) ? '1 : '0;
            r.hay = $urandom_range(1) ? '1 : '0;
            r.hbx = $urandom_range(1) ? '1 : '0;
            r.hby = $urandom_range(1) ? '1 : '0;
        end
        else if (mode > 2)
        begin
            // nearby boxes of moderate size, so most pairs overlap
            r.ax = $signed($urandom_range(1 << 20)) - (1 << 19);
            r.ay = $signed($urandom_range(1 << 20)) - (1 << 19);
            r.bx = r.ax + $signed($urandom_range(1 << 20)) - (1 << 19);
            r.by = r.ay + $signed($urandom_range(1 << 20)) - (1 << 19);
            r.hax = $urandom_range(6 << 16);
            r.hay = $urandom_range(6 << 16);
            r.hbx = $urandom_range(6 << 16);
            r.hby = $urandom_range(6 << 16);
            if (mode > 6)
            begin
                r.anga = 16'($urandom_range(3) << 14);
                r.angb = 16'($urandom_range(3) << 14);
            end
        end
        return r;
    endfunction

    // Offer one word, wait for it to be taken, then queue its expected result.
    task automatic send_word(input logic [IN_W-1:0] d, input logic [OUT_W-1:0] want);
        bit rdy;
        if (tx_idle > 0 && $urandom_range(99) < tx_idle)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        do
        begin
            @(negedge clk) rdy = s_axis_tready;
            @(posedge clk);
        end
        while (!rdy);
        pending_words.insert(pending_words.size(), want);
        words_in++;
    endtask

    task automatic run_random(input int n);
        pair_row_t r;
        for (int i = 0; i < n; i++)
        begin
            r = rand_pair();
            send_word(pack_pair(r), sat_contact(r));
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_tol(input logic [TOL_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        tol_now = v;
        @(posedge clk);
    endtask

    // receiver: random stalls, plus a long hold-off when requested
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= (rx_idle == 0) || ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge clk)
    begin
        logic [OUT_W-1:0] want;
        longint ev, av;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            words_out++;
            if (m_axis_tdata[0]) hits_seen++;
            if (pending_words.size() == 0)
            begin
                $display("%0t: result with nothing expected: %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = pending_words.pop_front();
                for (int f = 0; f < 9; f++)
                begin
                    ev = (want >> FLD_LO[f]) & ((64'd1 << FLD_W[f]) - 1);
                    av = (m_axis_tdata >> FLD_LO[f]) & ((64'd1 << FLD_W[f]) - 1);
                    if (ev != av)
                    begin
                        $display("%0t: %s mismatch, expected %h, actual %h",
                                 $time, FLD_NAME[f], ev, av);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        #3000000;
        $display("timeout with %0d results outstanding", pending_words.size());
        $display("obb_pair_sat_contact_top verification failed");
        $finish;
    end

    initial
    begin
        pair_row_t dir_rows[$];
        pair_row_t r;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // center_ax, center_ay, half_ax, half_ay, angle_a, B likewise, separated flag
        dir_rows.insert(dir_rows.size(), '{-32'sd2147483648, 0, 0, 0, 0,
                             32'sd2147483647, 0, 0, 0, 0, 1});
        dir_rows.insert(dir_rows.size(),
                        '{0, 0, 65536, 65536, 0, 32'sd655360, 0, 65536, 65536, 0, 1});
        dir_rows.insert(dir_rows.size(),
                        '{0, 0, 65536, 65536, 0, 0, 0, 65536, 65536, 0, 0});
        dir_rows.insert(dir_rows.size(),
                        '{0, 0, 65536, 65536, 0, 131072, 0, 65536, 65536, 0, 0});
        dir_rows.insert(dir_rows.size(),
                        '{0, 0, 65536, 65536, 0, -98304, 0, 65536, 65536, 0, 0});
        dir_rows.insert(dir_rows.size(),
                        '{0, 0, 65536, 32768, 16384, 0, 65536, 65536, 65536, 8192, 0});
        dir_rows.insert(dir_rows.size(), '{0, 0, 131072, 65536, 32768, 65536, -65536,
                             65536, 65536, 49152, 0});
        dir_rows.insert(dir_rows.size(), '{0, 0, 131072, 131072, 65535, 0, 131072,
                             65536, 65536, 12345, 0});
        dir_rows.insert(dir_rows.size(), '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        dir_rows.insert(dir_rows.size(), '{0, 0, 0, 0, 0, 0, 0, 65536, 65536, 40000, 0});
        dir_rows.insert(dir_rows.size(),
                        '{32'sd2147483647, 32'sd2147483647, '1, '1, 16'hFFFF,
                          -32'sd2147483648, -32'sd2147483648, '1, '1, 16'hFFFF, 0});
        dir_rows.insert(dir_rows.size(),
                        '{-32'sd2147483648, 32'sd2147483647, '1, 0, 8192,
                          32'sd2147483647, -32'sd2147483648, 0, '1, 24576, 0});
        dir_rows.insert(dir_rows.size(),
                        '{0, 0, 131072, 65536, 0, 32768, 98304, 65536, 65536, 0, 0});
        dir_rows.insert(dir_rows.size(),
                        '{100, -200, 65536, 65536, 0, 100, 131000, 65536, 65536, 300, 0});
        dir_rows.insert(dir_rows.size(),
                        '{0, 0, 65536, 65536, 0, 65536, 65536, 65536, 65536, 16384, 0});
        foreach (dir_rows[i])
        begin
            r = dir_rows[i];
            send_word(pack_pair(r), r.apart ? '0 : sat_contact(r));
        end
        drain();

        write_tol('0);
        tx_idle = 18; rx_idle = 81;
        run_random(200);
        drain();

        write_tol('1);
        tx_idle = 81; rx_idle = 18;
        run_random(200);
        drain();

        write_tol(16'($urandom));
        tx_idle = 0; rx_idle = 0;
        hold_left = 300;
        run_random(60);
        // hold the input until the pipe has emptied
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        run_random(140);
        drain();

        $display("sent %0d box pairs, checked %0d results, %0d of them hits",
                 words_in, words_out, hits_seen);
        $display("tolerance 655, 0, 65535 and a random value; input and output stalls");
        if (errors == 0 && pending_words.size() == 0)
            $display("obb_pair_sat_contact_top verification clean");
        else
            $display("obb_pair_sat_contact_top verification failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/obb_pkg.sv
rtl/core/obb_cordic.sv
rtl/core/obb_pair_sat_contact_top.sv
tb/obb_pair_sat_contact_top_tb.sv
